// File: sv/cpwc_pkg.sv
// ----------------------------------------------------------------------------
// cpwc_pkg: shared types and constants for the coin pulse width counter
// Holds the sample and result item types, the lane result and configuration
// structs, register indexes and reset values.
// ----------------------------------------------------------------------------
package cpwc_pkg;

	// fixed field widths
	localparam int LINES       = 6;
	localparam int OUT_CHANNELS = 6;
	localparam int TIME_IN_W   = 8;
	localparam int WIDTH_W     = 8;
	localparam int COUNT_W     = 8;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_WIDTH = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_WIDTH = 2'd1;

	// register reset values
	localparam logic [WIDTH_W-1:0] MIN_WIDTH_RST = 8'd20;
	localparam logic [WIDTH_W-1:0] MAX_WIDTH_RST = 8'd150;

	typedef struct packed {
		logic [LINES-1:0]     line_levels;
		logic [TIME_IN_W-1:0] time_now;
	} sample_t;

	typedef struct packed {
		logic [COUNT_W-1:0]      count_ch0;
		logic [COUNT_W-1:0]      count_ch1;
		logic [COUNT_W-1:0]      count_ch2;
		logic [COUNT_W-1:0]      count_ch3;
		logic [COUNT_W-1:0]      count_ch4;
		logic [COUNT_W-1:0]      count_ch5;
		logic [OUT_CHANNELS-1:0] new_coin_mask;
	} result_t;

	typedef struct packed {
		logic [WIDTH_W-1:0] min_width;
		logic [WIDTH_W-1:0] max_width;
	} cfg_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               coin;
	} lane_res_t;

endpackage

// File: sv/cpwc_lane.sv
// ----------------------------------------------------------------------------
// cpwc_lane: pulse width qualifier for one coin line
// Tracks one channel: idle, or waiting for the line to rise since a recorded
// start time. Qualifies each pulse against min and max width and counts coins.
// ----------------------------------------------------------------------------
module cpwc_lane #(
	parameter int TIME_WIDTH = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic                  low,
	input  logic [TIME_WIDTH-1:0] now,
	input  cpwc_pkg::cfg_t        cfg,
	output cpwc_pkg::lane_res_t   res
);
	import cpwc_pkg::*;

	// compare width covers both the elapsed time and the width registers
	localparam int EW = (TIME_WIDTH > WIDTH_W) ? TIME_WIDTH : WIDTH_W;

	logic                  waiting_q;
	logic [TIME_WIDTH-1:0] start_q;
	logic [COUNT_W-1:0]    count_q;

	logic                  waiting_d;
	logic                  start_load;
	logic                  coin;
	logic [TIME_WIDTH-1:0] elapsed;
	logic                  timeout;
	logic                  long_enough;
	logic [COUNT_W-1:0]    count_next;

	// measure the pulse, modulo the tick counter period
	assign elapsed     = now - start_q;
	assign timeout     = EW'(elapsed) > EW'(cfg.max_width);
	assign long_enough = EW'(elapsed) > EW'(cfg.min_width);

	// next state: timeout takes precedence over a rise
	always_comb begin
		waiting_d  = waiting_q;
		start_load = 1'b0;
		coin       = 1'b0;
		if (!waiting_q) begin
			if (low) begin
				waiting_d  = 1'b1;
				start_load = 1'b1;
			end
		end else if (timeout) begin
			waiting_d = 1'b0;
		end else if (!low) begin
			waiting_d = 1'b0;
			coin      = long_enough;
		end
	end

	assign count_next = count_q + COUNT_W'(coin);

	assign res.count = count_next;
	assign res.coin  = coin;

	// advance channel state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q <= 1'b0;
			count_q   <= '0;
		end else if (accept) begin
			waiting_q <= waiting_d;
			count_q   <= count_next;
		end
	end

	// record the start time of a new pulse
	always_ff @(posedge clk) begin
		if (accept && start_load) begin
			start_q <= now;
		end
	end

	a_coin_from_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		coin |-> waiting_q)
		else $error("coin counted by an idle channel");

	a_idle_after_coin: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && coin) |=> !waiting_q)
		else $error("channel still waiting after counting a coin");

	a_count_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("coin count changed without an item");

endmodule

// File: sv/cpwc_merge.sv
// ----------------------------------------------------------------------------
// cpwc_merge: lane merge and result buffer
// Gathers the lane results into one result item and holds it in a two-entry
// buffer (main register plus skid register) so input and output decouple.
// ----------------------------------------------------------------------------
module cpwc_merge #(
	parameter int CHANNELS = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  cpwc_pkg::lane_res_t lane_res [CHANNELS],
	output logic                sample_stall,
	output logic                result_valid,
	input  logic                result_stall,
	output cpwc_pkg::result_t   result
);
	import cpwc_pkg::*;

	logic [COUNT_W-1:0]      counts [OUT_CHANNELS];
	logic [OUT_CHANNELS-1:0] mask;
	result_t                 item;

	result_t main_q;
	result_t skid_q;
	logic    main_valid_q;
	logic    skid_valid_q;
	logic    pop;

	// combine lanes; missing channels read as zero
	for (genvar g = 0; g < OUT_CHANNELS; g++) begin : g_out
		if (g < CHANNELS) begin : g_lane
			assign counts[g] = lane_res[g].count;
			assign mask[g]   = lane_res[g].coin;
		end else begin : g_zero
			assign counts[g] = '0;
			assign mask[g]   = 1'b0;
		end
	end

	assign item.count_ch0     = counts[0];
	assign item.count_ch1     = counts[1];
	assign item.count_ch2     = counts[2];
	assign item.count_ch3     = counts[3];
	assign item.count_ch4     = counts[4];
	assign item.count_ch5     = counts[5];
	assign item.new_coin_mask = mask;

	assign pop          = main_valid_q && !result_stall;
	assign sample_stall = skid_valid_q;
	assign result_valid = main_valid_q;
	assign result       = main_q;

	// buffer control: refill main from skid first, else from the new item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					main_valid_q <= push;
				end
			end else if (push) begin
				if (main_valid_q) begin
					skid_valid_q <= 1'b1;
				end else begin
					main_valid_q <= 1'b1;
				end
			end
		end
	end

	// buffer payload
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= item;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_q <= item;
			end else begin
				main_q <= item;
			end
		end
	end

	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid entry held with main register empty");

	a_skid_fill_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(main_valid_q && result_stall))
		else $error("skid filled without a stalled result");

	a_refill_from_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && skid_valid_q) |=> main_valid_q)
		else $error("main register emptied while skid held an item");

endmodule

// File: sv/coin_pulse_width_counter.sv
// ----------------------------------------------------------------------------
// coin_pulse_width_counter: six-line coin pulse qualifier and counter
// Samples the active-low coin lines, qualifies each pulse by width and keeps
// one wrapping coin count per channel.
// ----------------------------------------------------------------------------
// One sample item is taken every clock cycle while not stalled; each of
// CHANNELS lanes updates its channel in the cycle the item is accepted, and
// the result item (all counts after this sample plus the new-coin mask) is
// registered in a two-entry output buffer. The input stalls only once both
// buffer entries hold results that the output side has not yet taken. Lines
// beyond the sixth read as idle. The configuration port is always ready;
// writes to an index other than min_width or max_width are dropped.
module coin_pulse_width_counter #(
	parameter int CHANNELS   = 6,
	parameter int TIME_WIDTH = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  sample_valid,
	output logic                                  sample_stall,
	input  cpwc_pkg::sample_t                     sample,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output cpwc_pkg::result_t                     result,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [cpwc_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [cpwc_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import cpwc_pkg::*;

	cfg_t                  cfg_q;
	logic                  accept;
	logic [CHANNELS-1:0]   low;
	logic [TIME_WIDTH-1:0] now;
	lane_res_t             lane_res [CHANNELS];

	assign cfg_ready = 1'b1;
	assign accept    = sample_valid && !sample_stall;
	assign now       = TIME_WIDTH'(sample.time_now);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_width <= MIN_WIDTH_RST;
			cfg_q.max_width <= MAX_WIDTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MIN_WIDTH: cfg_q.min_width <= WIDTH_W'(cfg_data);
				REG_MAX_WIDTH: cfg_q.max_width <= WIDTH_W'(cfg_data);
				default: ;
			endcase
		end
	end

	// one lane per channel; lines beyond the sampled ones stay idle
	for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
		if (g < LINES) begin : g_line
			assign low[g] = !sample.line_levels[g];
		end else begin : g_none
			assign low[g] = 1'b0;
		end

		cpwc_lane #(
			.TIME_WIDTH(TIME_WIDTH)
		) u_lane (
			.clk   (clk),
			.arst_n(arst_n),
			.accept(accept),
			.low   (low[g]),
			.now   (now),
			.cfg   (cfg_q),
			.res   (lane_res[g])
		);
	end

	// merge lanes into the result item
	cpwc_merge #(
		.CHANNELS(CHANNELS)
	) u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (accept),
		.lane_res    (lane_res),
		.sample_stall(sample_stall),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule

// File: tb/sv/cpwc_scoreboard.sv
// ----------------------------------------------------------------------------
// cpwc_scoreboard: result checking for the coin pulse width counter
// Watches the sample, result and register ports, keeps its own copy of the
// per-channel pulse state and coin counts, and compares every result item
// with the one predicted for the oldest accepted sample.
// ----------------------------------------------------------------------------
module cpwc_scoreboard (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             sample_valid,
	input  logic                             sample_stall,
	input  cpwc_pkg::sample_t                sample,
	input  logic                             result_valid,
	input  logic                             result_stall,
	input  cpwc_pkg::result_t                result,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [cpwc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [cpwc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                               fault_count,
	output int                               outstanding
);
	import cpwc_pkg::*;

	// predicted channel state and register copy
	logic                 waiting   [LINES];
	logic [TIME_IN_W-1:0] pulse_t0  [LINES];
	logic [COUNT_W-1:0]   coins     [LINES];
	logic [WIDTH_W-1:0]   min_w;
	logic [WIDTH_W-1:0]   max_w;
	result_t              predicted_results [$];
	result_t              want;

	initial begin
		fault_count = 0;
		outstanding = 0;
	end

	task automatic report_fault(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		fault_count++;
	endtask

	task automatic compare_field(input string name, input logic [7:0] got,
			input logic [7:0] exp_val);
		if (got !== exp_val)
			report_fault($sformatf("%s got %0h, predicted %0h", name, got, exp_val));
	endtask

	// advance every channel by one sample and build the result item
	function automatic result_t qualify_sample(input sample_t s);
		result_t              r;
		logic [TIME_IN_W-1:0] elapsed;
		logic [LINES-1:0]     mask;
		logic                 low;
		mask = '0;
		for (int ch = 0; ch < LINES; ch++) begin
			low = !s.line_levels[ch];
			if (!waiting[ch]) begin
				// the start sample checks nothing else
				if (low) begin
					waiting[ch]  = 1'b1;
					pulse_t0[ch] = s.time_now;
				end
			end else begin
				elapsed = s.time_now - pulse_t0[ch];
				// timeout wins over a rise
				if (elapsed > max_w) begin
					waiting[ch] = 1'b0;
				end else if (!low) begin
					waiting[ch] = 1'b0;
					if (elapsed > min_w) begin
						coins[ch] = coins[ch] + 1'b1;
						mask[ch]  = 1'b1;
					end
				end
			end
		end
		r.count_ch0     = coins[0];
		r.count_ch1     = coins[1];
		r.count_ch2     = coins[2];
		r.count_ch3     = coins[3];
		r.count_ch4     = coins[4];
		r.count_ch5     = coins[5];
		r.new_coin_mask = mask;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int ch = 0; ch < LINES; ch++) begin
				waiting[ch]  = 1'b0;
				pulse_t0[ch] = '0;
				coins[ch]    = '0;
			end
			min_w = MIN_WIDTH_RST;
			max_w = MAX_WIDTH_RST;
			predicted_results.delete();
		end else begin
			// compare the result item leaving the block
			if (result_valid && !result_stall) begin
				if (predicted_results.size() == 0) begin
					report_fault("result item with nothing predicted");
				end else begin
					want = predicted_results.pop_front();
					compare_field("count_ch0", result.count_ch0, want.count_ch0);
					compare_field("count_ch1", result.count_ch1, want.count_ch1);
					compare_field("count_ch2", result.count_ch2, want.count_ch2);
					compare_field("count_ch3", result.count_ch3, want.count_ch3);
					compare_field("count_ch4", result.count_ch4, want.count_ch4);
					compare_field("count_ch5", result.count_ch5, want.count_ch5);
					compare_field("new_coin_mask", 8'(result.new_coin_mask),
						8'(want.new_coin_mask));
				end
			end
			// track register writes; other indexes are dropped
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_MIN_WIDTH)
					min_w = cfg_data;
				else if (cfg_index == REG_MAX_WIDTH)
					max_w = cfg_data;
			end
			// predict for the accepted sample item
			if (sample_valid && !sample_stall)
				predicted_results.push_back(qualify_sample(sample));
		end
		outstanding = predicted_results.size();
	end

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the coin pulse width counter
// Drives directed coin pulses, long bursts and random pulse trains of widths
// around the qualifying limits through several register settings, with
// random idling on both sides and one long output hold-off. A scoreboard
// beside the block predicts and checks every result item.
// ----------------------------------------------------------------------------
module tb;
	import cpwc_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int HOLD_CYCLES  = 60;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

	logic                   clk;
	logic                   arst_n;
	logic                   sample_valid;
	logic                   sample_stall;
	sample_t                sample;
	logic                   result_valid;
	logic                   result_stall;
	result_t                result;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	int                     fault_count;
	int                     outstanding;
	int                     sender_idle_pct   = 34;
	int                     receiver_idle_pct = 80;
	int                     items_sent        = 0;
	int                     cycles            = 0;
	int                     hold_left         = 0;
	bit                     pressure_go       = 1'b0;
	bit                     pressure_done     = 1'b0;
	int unsigned            tick              = 0;
	int unsigned            release_at [LINES];
	logic [WIDTH_W-1:0]     cur_min           = MIN_WIDTH_RST;
	logic [WIDTH_W-1:0]     cur_max           = MAX_WIDTH_RST;
	logic [WIDTH_W-1:0]     lo;

	coin_pulse_width_counter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	cpwc_scoreboard u_scoreboard (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fault_count  (fault_count),
		.outstanding  (outstanding)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// give up on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("coin_pulse_width_counter verification failed");
			$finish;
		end
	end

	// output side: one long hold-off when asked, otherwise random stalls
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left    <= hold_left - 1;
			result_stall <= 1'b1;
		end else if (pressure_go && !pressure_done) begin
			pressure_done <= 1'b1;
			hold_left     <= HOLD_CYCLES;
			result_stall  <= 1'b1;
		end else begin
			result_stall <= (int'($urandom_range(99)) < receiver_idle_pct);
		end
	end

	// offer one sample item, idling first at random, and wait for it to go in
	task automatic send_sample(input logic [LINES-1:0] levels,
			input logic [TIME_IN_W-1:0] stamp);
		sample_t s;
		s.line_levels = levels;
		s.time_now    = stamp;
		while (int'($urandom_range(99)) < sender_idle_pct) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample       <= s;
		sample_valid <= 1'b1;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		items_sent++;
		// receiver idles first, then the sender, then neither
		if (items_sent < 310) begin
			sender_idle_pct   = 34;
			receiver_idle_pct = 80;
		end else if (items_sent < 620) begin
			sender_idle_pct   = 80;
			receiver_idle_pct = 34;
		end else begin
			sender_idle_pct   = 0;
			receiver_idle_pct = 0;
		end
		@(negedge clk);
	endtask

	// hold the register item until taken; the caller drops valid
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_widths(input logic [WIDTH_W-1:0] min_val,
			input logic [WIDTH_W-1:0] max_val);
		write_reg(REG_MIN_WIDTH, min_val);
		write_reg(REG_MAX_WIDTH, max_val);
		cfg_valid <= 1'b0;
		cur_min = min_val;
		cur_max = max_val;
	endtask

	// stop offering and let every predicted result come out
	task automatic drain();
		sample_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// pulse width near either limit, or anything up to past one time wrap
	function automatic int pick_duration();
		int r;
		int d;
		r = int'($urandom_range(9));
		if (r < 3)
			d = int'(cur_min) + int'($urandom_range(4)) - 2;
		else if (r < 6)
			d = int'(cur_max) + int'($urandom_range(4)) - 2;
		else if (r < 8)
			d = int'($urandom_range(1, 40));
		else
			d = int'($urandom_range(300));
		return (d < 1) ? 1 : d;
	endfunction

	// random pulse trains on all lines, with some noise items
	task automatic run_pulses(input int n);
		logic [LINES-1:0] levels;
		int               r;
		int unsigned      step;
		for (int k = 0; k < n; k++) begin
			r = int'($urandom_range(99));
			if (r < 5)
				step = 0;
			else if (r < 85)
				step = $urandom_range(1, 6);
			else if (r < 95)
				step = $urandom_range(7, 40);
			else
				step = $urandom_range(41, 200);
			tick += step;
			for (int ch = 0; ch < LINES; ch++) begin
				if (tick >= release_at[ch] && $urandom_range(3) == 0)
					release_at[ch] = tick + pick_duration();
				levels[ch] = (tick >= release_at[ch]);
			end
			if ($urandom_range(99) < 8)
				send_sample(LINES'($urandom), TIME_IN_W'($urandom));
			else
				send_sample(levels, tick[TIME_IN_W-1:0]);
		end
	endtask

	// short pulses on every line, enough to wrap the coin counts
	task automatic run_burst(input int n);
		logic [LINES-1:0] levels;
		for (int k = 0; k < n; k++) begin
			tick += $urandom_range(1, 4);
			levels = (k % 2 == 1) ? '1 : '0;
			if ($urandom_range(9) == 0)
				levels ^= LINES'($urandom);
			send_sample(levels, tick[TIME_IN_W-1:0]);
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		sample_valid = 1'b0;
		sample       = '0;
		result_stall = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = REG_MIN_WIDTH;
		cfg_data     = '0;
		for (int ch = 0; ch < LINES; ch++)
			release_at[ch] = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed pulses under the reset widths
		send_sample(6'b111111, 8'd0);
		send_sample(6'b000000, 8'd10);    // every line starts
		send_sample(6'b000001, 8'd30);    // width equal to min: no coin
		send_sample(6'b000011, 8'd31);    // just above min: coin
		send_sample(6'b000111, 8'd160);   // equal to max: coin
		send_sample(6'b010111, 8'd161);   // past max: timeout, even on a rise
		send_sample(6'b010111, 8'd162);   // low lines start again
		send_sample(6'b111111, 8'd163);   // too short
		send_sample(6'b111110, 8'd250);
		send_sample(6'b111111, 8'd20);    // across the time wrap: coin
		send_sample(6'b000000, 8'd255);
		send_sample(6'b111111, 8'd40);
		tick = 40;
		run_pulses(60);

		drain();
		set_widths(8'd0, 8'd255);
		run_burst(540);

		// min at or above max: nothing counts
		drain();
		set_widths(8'd255, 8'd0);
		run_pulses(60);

		drain();
		set_widths(8'd0, 8'd0);
		run_pulses(50);

		drain();
		set_widths(8'd255, 8'd255);
		run_pulses(50);

		// fill the block while the output holds off
		drain();
		pressure_go = 1'b1;
		set_widths(WIDTH_W'($urandom), WIDTH_W'($urandom));
		run_pulses(60);

		drain();
		lo = WIDTH_W'($urandom_range(60));
		set_widths(lo, lo + WIDTH_W'($urandom_range(10, 100)));
		run_pulses(60);

		// writes to unused indexes must change nothing
		drain();
		write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
		write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
		set_widths(MIN_WIDTH_RST, MAX_WIDTH_RST);
		run_pulses(60);

		drain();
		repeat (8) @(negedge clk);
		if (fault_count == 0)
			$display("coin_pulse_width_counter verification clean");
		else
			$display("coin_pulse_width_counter verification failed");
		$finish;
	end

endmodule
